>>> hw/rtl/ack_packet_deframer_checker_macros.svh
// Assertion macros shared by the deframer RTL files.
`ifndef ACK_PACKET_DEFRAMER_CHECKER_MACROS_SVH
`define ACK_PACKET_DEFRAMER_CHECKER_MACROS_SVH

`ifndef SYNTHESIS

`define APDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define APDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define APDC_ASSERT_IMP(lbl, ante, cons, msg)

`define APDC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/apdc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the deframer.
package apdc_pkg;

  localparam int unsigned MaxPayloadDef  = 1024;
  localparam int unsigned ReportBytesDef = 64;
  localparam int unsigned LenW           = 11;
  localparam int unsigned WideW          = 18;

  localparam logic [7:0]  AckCommand = 8'hB0;
  localparam logic [15:0] CrcPoly    = 16'hA001;
  localparam logic [15:0] CrcInit    = 16'hFFFF;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StXferErr = 2'd1,
    StBizErr  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       report_start;
  } item_t;

  typedef struct packed {
    status_e         status;
    logic [7:0]      ack_code;
    logic [LenW-1:0] payload_length;
  } res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/apdc_in_reg.sv
// Input register: holds one accepted byte until the core takes it.
module apdc_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  apdc_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           vld_o,
  output apdc_pkg::item_t item_o
);
  import apdc_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q;
  logic  accept;

  assign in_stall_o = vld_q & ~advance_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign vld_d      = accept | (vld_q & ~advance_i);
  assign vld_o      = vld_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

endmodule

>>> hw/rtl/apdc_core.sv
// Packet state and single-pass byte update: header, block check, business CRC.
`include "ack_packet_deframer_checker_macros.svh"

module apdc_core #(
  parameter int unsigned MaxPayload  = apdc_pkg::MaxPayloadDef,
  parameter int unsigned ReportBytes = apdc_pkg::ReportBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_data_i,
  input  logic           item_vld_i,
  input  apdc_pkg::item_t item_i,
  input  logic           out_free_i,
  output logic           advance_o,
  output logic           res_push_o,
  output apdc_pkg::res_t res_o
);
  import apdc_pkg::*;

  localparam int unsigned PosW = $clog2(ReportBytes + 1);
  localparam int unsigned CntW = $clog2(MaxPayload + ReportBytes + 9);

  logic [7:0]      header_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     tlen_q, tlen_d;
  logic [7:0]      bcc_q, bcc_d;
  logic            first_q, first_d;
  logic            skip_q, skip_d;
  logic            open_q, open_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     blen_q, blen_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [7:0]      code_q, code_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crclo_q, crclo_d;
  logic            perr_q, perr_d;

  logic            start;
  logic [7:0]      b;
  logic            skip_s, open_s;
  logic [PosW-1:0] pos_s;
  logic [7:0]      bcc_s;
  logic [15:0]     tlen_n5;
  logic            in_payload, overshoot5;

  logic [WideW-1:0] idx_w, lw, total_w, cnt_w;
  logic [15:0]      blen_b, len_hi;
  logic [15:0]      crc_b;
  logic [7:0]       crclo_b;
  logic [CntW-1:0]  cnt_b;
  logic             perr_b;

  logic             res_vld_c;
  res_t             res_c;

  assign start   = item_i.report_start;
  assign b       = item_i.rx_byte;
  assign skip_s  = skip_q & ~start;
  assign pos_s   = start ? '0 : pos_q;
  assign bcc_s   = start ? 8'h00 : bcc_q;
  assign open_s  = open_q & ~(start & ~skip_q & (pos_q != '0));
  assign tlen_n5 = {b, tlen_q[7:0]};

  assign in_payload = WideW'(pos_s) < (WideW'(tlen_q) + WideW'(6));
  assign overshoot5 = (WideW'(tlen_n5) + WideW'(7)) > WideW'(ReportBytes);

  // business byte update
  assign idx_w  = WideW'(cnt_q);
  assign len_hi = {b, blen_q[7:0]};

  always_comb begin
    blen_b = blen_q;
    if (cnt_q == CntW'(3)) begin
      blen_b = {8'h00, b};
    end else if (cnt_q == CntW'(4)) begin
      blen_b = len_hi;
    end
  end

  assign lw     = WideW'(blen_b);
  assign perr_b = perr_q | ((cnt_q == CntW'(4)) && (WideW'(len_hi) > WideW'(MaxPayload)));

  always_comb begin
    crc_b   = crc_q;
    crclo_b = crclo_q;
    cnt_b   = cnt_q;
    priority if ((idx_w < WideW'(5)) || (idx_w < lw + WideW'(5))) begin
      crc_b = crc_feed(crc_q, b);
    end else if (idx_w == lw + WideW'(5)) begin
      crclo_b = b;
    end else if (idx_w == lw + WideW'(6)) begin
      crc_b = crc_q ^ {b, crclo_q};
    end else begin
      crc_b = crc_q;
    end
    if ((idx_w < WideW'(5)) || (idx_w <= lw + WideW'(7))) begin
      cnt_b = cnt_q + CntW'(1);
    end
  end

  assign total_w = WideW'(blen_q) + WideW'(7);
  assign cnt_w   = WideW'(cnt_q);

  always_comb begin
    pos_d     = pos_s;
    tlen_d    = tlen_q;
    bcc_d     = bcc_s;
    first_d   = first_q;
    skip_d    = skip_s;
    open_d    = open_s;
    cnt_d     = cnt_q;
    blen_d    = blen_q;
    cmd_d     = cmd_q;
    code_d    = code_q;
    crc_d     = crc_q;
    crclo_d   = crclo_q;
    perr_d    = perr_q;
    res_vld_c = 1'b0;
    res_c     = '{status: StOk, ack_code: 8'h00, payload_length: '0};

    if (!skip_s) begin
      pos_d = pos_s + PosW'(1);
      if (pos_s == '0) begin
        if (b != header_q) begin
          res_vld_c    = 1'b1;
          res_c.status = StXferErr;
        end
      end else if (pos_s <= PosW'(5)) begin
        bcc_d = bcc_s ^ b;
        if (pos_s == PosW'(3)) begin
          first_d = b[7];
        end else if (pos_s == PosW'(4)) begin
          tlen_d = {8'h00, b};
        end else if (pos_s == PosW'(5)) begin
          tlen_d = tlen_n5;
          if (overshoot5) begin
            res_vld_c    = 1'b1;
            res_c.status = StXferErr;
          end else if (first_q) begin
            open_d  = 1'b1;
            cnt_d   = '0;
            blen_d  = 16'h0000;
            cmd_d   = 8'h00;
            code_d  = 8'h00;
            crc_d   = CrcInit;
            crclo_d = 8'h00;
            perr_d  = tlen_n5 < 16'd7;
          end else if (!open_s) begin
            skip_d = 1'b1;
          end
        end
      end else if (in_payload) begin
        bcc_d   = bcc_s ^ b;
        blen_d  = blen_b;
        crc_d   = crc_b;
        crclo_d = crclo_b;
        cnt_d   = cnt_b;
        perr_d  = perr_b;
        if (cnt_q == '0) begin
          cmd_d = b;
        end else if (cnt_q == CntW'(1)) begin
          code_d = b;
        end
      end else begin
        priority if (b != bcc_s) begin
          res_vld_c    = 1'b1;
          res_c.status = StXferErr;
        end else if (perr_q) begin
          res_vld_c    = 1'b1;
          res_c.status = StBizErr;
        end else if (cnt_w == total_w) begin
          res_vld_c = 1'b1;
          if ((cmd_q != AckCommand) || (crc_q != 16'h0000)) begin
            res_c.status = StBizErr;
          end else begin
            res_c.status         = StOk;
            res_c.ack_code       = code_q;
            res_c.payload_length = blen_q[LenW-1:0];
          end
        end else if (cnt_w > total_w) begin
          res_vld_c    = 1'b1;
          res_c.status = StBizErr;
        end else begin
          skip_d = 1'b1;
        end
      end
      if (res_vld_c) begin
        skip_d = 1'b1;
        open_d = 1'b0;
      end
    end
  end

  assign advance_o  = item_vld_i & (~res_vld_c | out_free_i);
  assign res_push_o = advance_o & res_vld_c;
  assign res_o      = res_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= 8'h00;
      pos_q    <= '0;
      tlen_q   <= 16'h0000;
      bcc_q    <= 8'h00;
      first_q  <= 1'b0;
      skip_q   <= 1'b1;
      open_q   <= 1'b0;
      cnt_q    <= '0;
      blen_q   <= 16'h0000;
      cmd_q    <= 8'h00;
      code_q   <= 8'h00;
      crc_q    <= CrcInit;
      crclo_q  <= 8'h00;
      perr_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        header_q <= cfg_data_i;
      end
      if (advance_o) begin
        pos_q   <= pos_d;
        tlen_q  <= tlen_d;
        bcc_q   <= bcc_d;
        first_q <= first_d;
        skip_q  <= skip_d;
        open_q  <= open_d;
        cnt_q   <= cnt_d;
        blen_q  <= blen_d;
        cmd_q   <= cmd_d;
        code_q  <= code_d;
        crc_q   <= crc_d;
        crclo_q <= crclo_d;
        perr_q  <= perr_d;
      end
    end
  end

  `APDC_ASSERT_IMP(a_err_fields_zero, res_push_o && (res_o.status != StOk), (res_o.ack_code == 8'h00) && (res_o.payload_length == '0), "error result carries nonzero fields")
  `APDC_ASSERT_NXT(a_result_closes, res_push_o, skip_q && !open_q, "result did not close the packet")
  `APDC_ASSERT_IMP(a_pos_in_report, !skip_q, pos_q < PosW'(ReportBytes), "byte position beyond report")

endmodule

>>> hw/rtl/apdc_out_reg.sv
// Result register: holds one result until the downstream side takes it.
`include "ack_packet_deframer_checker_macros.svh"

module apdc_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  apdc_pkg::res_t res_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output apdc_pkg::res_t res_o,
  output logic           free_o
);
  import apdc_pkg::*;

  logic vld_q;
  res_t res_q;

  assign free_o      = ~vld_q | ~out_stall_i;
  assign out_valid_o = vld_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (push_i) begin
      vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  `APDC_ASSERT_IMP(a_push_into_free, push_i, !(vld_q && out_stall_i), "result pushed over a held result")
  `APDC_ASSERT_NXT(a_push_lands, push_i, vld_q && (res_q == $past(res_i)), "pushed result not held")

endmodule

>>> hw/rtl/ack_packet_deframer_checker.sv
// Top level of the acknowledgement packet deframer and checker.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  in      | in        | in_valid_i/in_stall_o | rx_byte_i, report_start_i
//  out     | out       | out_valid_o/out_stall_i | status_o, ack_code_o, payload_length_o
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_data_i (header byte)
//
// One byte per cycle while no held result stalls the input; a byte lands in the input
// register at its transfer and is folded into the packet state when the core advances,
// which also loads its result (if any) into the output register.
// The CRC-16 byte update and block check are combinational in the core.
// Reset leaves the block waiting for a report start with header byte 0.
// A held result stalls the input only when the next byte would produce another one.
module ack_packet_deframer_checker #(
  parameter int unsigned MaxPayload  = apdc_pkg::MaxPayloadDef,
  parameter int unsigned ReportBytes = apdc_pkg::ReportBytesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                rx_byte_i,
  input  logic                      report_start_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [7:0]                ack_code_o,
  output logic [apdc_pkg::LenW-1:0] payload_length_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [7:0]                cfg_data_i
);
  import apdc_pkg::*;

  item_t item_in, item_q;
  logic  item_vld;
  logic  advance;
  logic  res_push;
  logic  out_free;
  res_t  res_c, res_q;

  assign item_in.rx_byte      = rx_byte_i;
  assign item_in.report_start = report_start_i;

  assign cfg_ready_o = ~item_vld;

  apdc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .vld_o      (item_vld),
    .item_o     (item_q)
  );

  apdc_core #(
    .MaxPayload  (MaxPayload),
    .ReportBytes (ReportBytes)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .item_vld_i (item_vld),
    .item_i     (item_q),
    .out_free_i (out_free),
    .advance_o  (advance),
    .res_push_o (res_push),
    .res_o      (res_c)
  );

  apdc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .res_i       (res_c),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_q),
    .free_o      (out_free)
  );

  assign status_o         = res_q.status;
  assign ack_code_o       = res_q.ack_code;
  assign payload_length_o = res_q.payload_length;

endmodule

>>> tb/ack_packet_deframer_checker_tb.sv
// Self-checking testbench for the acknowledgement packet deframer and checker.
`timescale 1ns / 1ps

module ack_packet_deframer_checker_tb;
  import apdc_pkg::*;

  localparam int unsigned MaxPayload    = MaxPayloadDef;
  localparam int unsigned ReportBytes   = ReportBytesDef;
  localparam int unsigned MaxChunk      = ReportBytes - 7;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned TimeoutNs     = 5_000_000;

  typedef struct {
    logic [7:0] data;
    logic       start;
    bit         given;
    res_t       res;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i;
  logic                report_start_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [1:0]          status_o;
  logic [7:0]          ack_code_o;
  logic [LenW-1:0]     payload_length_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [7:0]          cfg_data_i;

  ack_packet_deframer_checker DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .report_start_i   (report_start_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .ack_code_o       (ack_code_o),
    .payload_length_o (payload_length_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  // Deframer state mirror.
  logic [7:0]  hdr_cfg;
  logic [6:0]  byte_pos;
  logic [15:0] xfer_len;
  logic [7:0]  bcc;
  bit          first_flag;
  bit          skipping;
  bit          biz_open;
  logic [10:0] biz_count;
  logic [15:0] biz_len;
  logic [7:0]  cmd_byte;
  logic [7:0]  code_byte;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo;
  bit          len_err;

  res_t        expected_acks[$];
  res_t        predicted_ack;
  res_t        oldest_ack;
  bit          ack_fired;
  bit          row_given;
  res_t        row_res;
  int unsigned mismatch_count;
  int unsigned bytes_sent;
  int unsigned acks_seen;
  int unsigned idle_pct;
  int unsigned phase_base;
  bit          quiet;
  bit          hold_off_req;
  logic [7:0]  biz_q[$];

  stim_row_t dir_rows [23] = '{
    '{8'hA5, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{StXferErr, 8'h00, 11'd0}},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, '{StXferErr, 8'h00, 11'd0}},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'hC3, 1'b0, 1'b0, '0},
    '{8'h3C, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b1, '{StBizErr, 8'h00, 11'd0}}
  };

  int unsigned phase_len [4] = '{120, 0, 20, 40};
  logic [7:0]  phase_hdr [4] = '{8'hFF, 8'h00, 8'h00, 8'h80};

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [15:0] modbus_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic void reset_deframer();
    hdr_cfg    = 8'h00;
    byte_pos   = '0;
    xfer_len   = '0;
    bcc        = '0;
    first_flag = 1'b0;
    skipping   = 1'b1;
    biz_open   = 1'b0;
    biz_count  = '0;
    biz_len    = '0;
    cmd_byte   = '0;
    code_byte  = '0;
    crc_acc    = CrcInit;
    crc_lo     = '0;
    len_err    = 1'b0;
  endfunction

  function automatic res_t ack_close(input status_e st, input logic [7:0] code_v,
                                     input logic [15:0] len_v);
    res_t r;
    r.status         = st;
    r.ack_code       = code_v;
    r.payload_length = len_v[LenW-1:0];
    skipping = 1'b1;
    biz_open = 1'b0;
    return r;
  endfunction

  function automatic void absorb_biz_byte(input logic [7:0] b);
    logic [10:0] idx;
    idx = biz_count;
    if (idx == 0) begin
      cmd_byte = b;
    end else if (idx == 1) begin
      code_byte = b;
    end else if (idx == 3) begin
      biz_len = {8'h00, b};
    end else if (idx == 4) begin
      biz_len = {b, biz_len[7:0]};
      if (biz_len > MaxPayload) len_err = 1'b1;
    end
    if (idx < 5 || idx < 5 + biz_len) begin
      crc_acc = modbus_step(crc_acc, b);
    end else if (idx == 5 + biz_len) begin
      crc_lo = b;
    end else if (idx == 6 + biz_len) begin
      crc_acc = crc_acc ^ {b, crc_lo};
    end
    if (idx < 5 || idx <= biz_len + 7) biz_count = idx + 1'b1;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, input logic start, output res_t r);
    logic [6:0] p;
    r = '0;
    if (start) begin
      if (!skipping && byte_pos != 0) biz_open = 1'b0;
      byte_pos = '0;
      skipping = 1'b0;
      bcc      = '0;
    end
    if (skipping) return 1'b0;
    p = byte_pos;
    byte_pos = p + 1'b1;
    if (p == 0) begin
      if (b != hdr_cfg) begin
        r = ack_close(StXferErr, 8'h00, 16'h0000);
        return 1'b1;
      end
      return 1'b0;
    end
    if (p <= 5) begin
      bcc = bcc ^ b;
      if (p == 3) begin
        first_flag = b[7];
      end else if (p == 4) begin
        xfer_len = {8'h00, b};
      end else if (p == 5) begin
        xfer_len = {b, xfer_len[7:0]};
        if (xfer_len + 7 > ReportBytes) begin
          r = ack_close(StXferErr, 8'h00, 16'h0000);
          return 1'b1;
        end
        if (first_flag) begin
          biz_open  = 1'b1;
          biz_count = '0;
          biz_len   = '0;
          cmd_byte  = '0;
          code_byte = '0;
          crc_acc   = CrcInit;
          crc_lo    = '0;
          len_err   = xfer_len < 7;
        end else if (!biz_open) begin
          skipping = 1'b1;
        end
      end
      return 1'b0;
    end
    if (p < 6 + xfer_len) begin
      bcc = bcc ^ b;
      absorb_biz_byte(b);
      return 1'b0;
    end
    if (b != bcc) begin
      r = ack_close(StXferErr, 8'h00, 16'h0000);
      return 1'b1;
    end
    if (len_err) begin
      r = ack_close(StBizErr, 8'h00, 16'h0000);
      return 1'b1;
    end
    if (biz_count == biz_len + 7) begin
      if (cmd_byte != AckCommand || crc_acc != 16'h0000) begin
        r = ack_close(StBizErr, 8'h00, 16'h0000);
      end else begin
        r = ack_close(StOk, code_byte, biz_len);
      end
      return 1'b1;
    end
    if (biz_count > biz_len + 7) begin
      r = ack_close(StBizErr, 8'h00, 16'h0000);
      return 1'b1;
    end
    skipping = 1'b1;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_acks.size() == 0) begin
          report_mismatch("unexpected result, status", status_o, 0);
        end else begin
          oldest_ack = expected_acks.pop_front();
          acks_seen++;
          if (status_o != oldest_ack.status)
            report_mismatch("status", status_o, oldest_ack.status);
          if (ack_code_o != oldest_ack.ack_code)
            report_mismatch("ack_code", ack_code_o, oldest_ack.ack_code);
          if (payload_length_o != oldest_ack.payload_length)
            report_mismatch("payload_length", payload_length_o, oldest_ack.payload_length);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        ack_fired = deframe_byte(rx_byte_i, report_start_i, predicted_ack);
        if (row_given) begin
          expected_acks.push_back(row_res);
        end else if (ack_fired) begin
          expected_acks.push_back(predicted_ack);
        end
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic put_byte(input logic [7:0] data, input logic start,
                          input bit given = 1'b0, input res_t res = '0);
    in_valid_i     <= 1'b1;
    rx_byte_i      <= data;
    report_start_i <= start;
    row_given      <= given;
    row_res        <= res;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_acks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_header(input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    hdr_cfg = value;
    cfg_valid_i <= 1'b0;
  endtask

  // One transfer packet carrying biz_q[from +: n], with an occasional flaw.
  task automatic send_packet(input int unsigned from, input int unsigned n, input bit first);
    logic [7:0]  pkt[$];
    logic [7:0]  x;
    logic [15:0] len_f;
    int unsigned flaw;
    flaw  = $urandom_range(0, 99);
    len_f = (flaw >= 8 && flaw < 10) ? 16'($urandom_range(MaxChunk + 1, 65535)) : 16'(n);
    pkt.push_back(flaw < 3 ? hdr_cfg ^ 8'($urandom_range(1, 255)) : hdr_cfg);
    pkt.push_back(8'($urandom));
    pkt.push_back(8'($urandom));
    pkt.push_back({first, 7'($urandom)});
    pkt.push_back(len_f[7:0]);
    pkt.push_back(len_f[15:8]);
    for (int unsigned i = 0; i < n; i++) pkt.push_back(biz_q[from + i]);
    x = 8'h00;
    for (int i = 1; i < pkt.size(); i++) x = x ^ pkt[i];
    pkt.push_back((flaw >= 3 && flaw < 6) ? x ^ 8'($urandom_range(1, 255)) : x);
    if (flaw >= 6 && flaw < 8) begin
      pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];
    end else if (flaw >= 8 && flaw < 10) begin
      pkt = pkt[0:5];
    end
    for (int i = 0; i < pkt.size(); i++) put_byte(pkt[i], i == 0);
    if (!(flaw >= 6 && flaw < 8)) begin
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic send_business(input bit biggest);
    logic [15:0] plen;
    logic [15:0] c;
    int unsigned pick;
    int unsigned from;
    int unsigned n;
    int unsigned total;
    biz_q = {};
    pick  = $urandom_range(0, 99);
    if (biggest) begin
      plen = 16'(MaxPayload);
    end else if (pick < 4) begin
      plen = 16'($urandom_range(MaxPayload + 1, 65535));
    end else if (pick < 14) begin
      plen = 16'($urandom_range(41, 200));
    end else begin
      plen = 16'($urandom_range(0, 40));
    end
    biz_q.push_back($urandom_range(0, 9) == 0 ? 8'($urandom) : AckCommand);
    biz_q.push_back(8'($urandom));
    biz_q.push_back(8'($urandom));
    biz_q.push_back(plen[7:0]);
    biz_q.push_back(plen[15:8]);
    if (plen > MaxPayload) begin
      repeat ($urandom_range(2, 40)) biz_q.push_back(8'($urandom));
    end else begin
      repeat (plen) biz_q.push_back(8'($urandom));
      c = CrcInit;
      foreach (biz_q[i]) c = modbus_step(c, biz_q[i]);
      if (!biggest && $urandom_range(0, 11) == 0) c = c ^ 16'($urandom_range(1, 65535));
      biz_q.push_back(c[7:0]);
      biz_q.push_back(c[15:8]);
      if (!biggest && $urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 4)) biz_q.push_back(8'($urandom));
      end
    end
    total = biz_q.size();
    n = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 6) : $urandom_range(7, MaxChunk);
    if (n > total) n = total;
    send_packet(0, n, 1'b1);
    from = n;
    while (from < total) begin
      if (!biggest && $urandom_range(0, 49) == 0) break;
      n = $urandom_range(0, MaxChunk);
      if (n > total - from) n = total - from;
      send_packet(from, n, 1'b0);
      from += n;
    end
  endtask

  task automatic send_random_unit();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      send_business(1'b0);
    end else if (pick < 92) begin
      biz_q = {};
      repeat (MaxChunk) biz_q.push_back(8'($urandom));
      send_packet(0, $urandom_range(0, 20), 1'b0);
    end else begin
      repeat ($urandom_range(1, 4)) put_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    rx_byte_i      = 8'h00;
    report_start_i = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = 8'h00;
    row_given      = 1'b0;
    row_res        = '0;
    mismatch_count = 0;
    bytes_sent     = 0;
    acks_seen      = 0;
    idle_pct       = 20;
    phase_base     = 0;
    quiet          = 1'b0;
    hold_off_req   = 1'b0;
    reset_deframer();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      put_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].given, dir_rows[i].res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_header(ph == 1 ? 8'($urandom_range(1, 254)) : phase_hdr[ph]);
      idle_pct = (ph == 1 || ph == 3) ? 0 : 15;
      quiet    = (ph == 3);
      if (ph == 0) hold_off_req = 1'b1;
      phase_base = bytes_sent;
      if (ph == 1) send_business(1'b1);
      while (bytes_sent < phase_base + phase_len[ph] || (ph == 3 && acks_seen < 48))
        send_random_unit();
    end
    drain();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/apdc_pkg.sv
hw/rtl/apdc_in_reg.sv
hw/rtl/apdc_core.sv
hw/rtl/apdc_out_reg.sv
hw/rtl/ack_packet_deframer_checker.sv
tb/ack_packet_deframer_checker_tb.sv
